[src/rrsd_pkg.sv]
package rrsd_pkg;

  localparam int WORD_W   = 32;
  localparam int STATUS_W = 4;
  localparam int PIDX_W   = 7;

  // Dense status codes of a finished reply
  localparam logic [STATUS_W-1:0] ST_OK            = 4'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_RPC       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_RPC_MISMATCH  = 4'd2;
  localparam logic [STATUS_W-1:0] ST_AUTH          = 4'd3;
  localparam logic [STATUS_W-1:0] ST_NEED_AUTH     = 4'd4;
  localparam logic [STATUS_W-1:0] ST_PROG_UNAVAIL  = 4'd5;
  localparam logic [STATUS_W-1:0] ST_PROG_MISMATCH = 4'd6;
  localparam logic [STATUS_W-1:0] ST_PROC_UNAVAIL  = 4'd7;
  localparam logic [STATUS_W-1:0] ST_XID_MISMATCH  = 4'd8;

  // Protocol word values
  localparam logic [WORD_W-1:0] MSG_REPLY        = 32'd1;
  localparam logic [WORD_W-1:0] RSTAT_ACCEPTED   = 32'd0;
  localparam logic [WORD_W-1:0] RSTAT_DENIED     = 32'd1;
  localparam logic [WORD_W-1:0] REJ_RPC_MISM     = 32'd0;
  localparam logic [WORD_W-1:0] REJ_AUTH_ERR     = 32'd1;
  localparam logic [WORD_W-1:0] AUTH_CRED_BAD    = 32'd1;
  localparam logic [WORD_W-1:0] AUTH_REJCRED     = 32'd2;
  localparam logic [WORD_W-1:0] AUTH_WEAK_FLAVOR = 32'd5;
  localparam logic [WORD_W-1:0] ACC_SUCCESS      = 32'd0;
  localparam logic [WORD_W-1:0] ACC_PROG_UNAV    = 32'd1;
  localparam logic [WORD_W-1:0] ACC_PROG_MISM    = 32'd2;
  localparam logic [WORD_W-1:0] ACC_PROC_UNAV    = 32'd3;

  typedef struct packed {
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic [PIDX_W-1:0]   payload_index;
  } rrsd_res_t;

endpackage

[src/rrsd_parser.sv]
module rrsd_parser
  import rrsd_pkg::*;
#(
  parameter int MAX_VERF_BYTES = 400
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  logic              step,
  input  logic [WORD_W-1:0] reply_word,
  input  logic              first_word,
  input  logic [WORD_W-1:0] expected_xid,
  output rrsd_res_t         res
);

  localparam int SKIP_MAX = (MAX_VERF_BYTES + 3) / 4;
  localparam int SKIP_W   = (SKIP_MAX > 1) ? $clog2(SKIP_MAX + 1) : 1;
  localparam int LEN_W    = SKIP_W + 2;
  localparam logic [WORD_W-1:0] MAX_LEN = WORD_W'(MAX_VERF_BYTES);

  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_MTYPE   = 4'd1,
    PH_RSTAT   = 4'd2,
    PH_REJECT  = 4'd3,
    PH_AUTH    = 4'd4,
    PH_VFLAVOR = 4'd5,
    PH_VLEN    = 4'd6,
    PH_VSKIP   = 4'd7,
    PH_ACCEPT  = 4'd8,
    PH_DONE    = 4'd9
  } phase_t;

  phase_t              phase_r, phase_nxt;
  logic [SKIP_W-1:0]   skip_left_r, skip_left_nxt;
  logic [PIDX_W-1:0]   word_index_r, word_index_nxt;
  logic [LEN_W:0]      len_round;

  assign len_round = {1'b0, reply_word[LEN_W-1:0]} + (LEN_W+1)'(3);

  always_comb begin
    phase_nxt      = phase_r;
    skip_left_nxt  = skip_left_r;
    word_index_nxt = word_index_r;
    res            = '0;
    if (item_valid && first_word) begin
      word_index_nxt = '0;
      skip_left_nxt  = '0;
      if (reply_word != expected_xid) begin
        res.hit    = 1'b1;
        res.status = ST_XID_MISMATCH;
        phase_nxt  = PH_DONE;
      end else begin
        phase_nxt = PH_MTYPE;
      end
    end else if (item_valid) begin
      unique case (phase_r)
        PH_MTYPE: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          if (reply_word != MSG_REPLY) begin
            res.hit    = 1'b1;
            res.status = ST_BAD_RPC;
            phase_nxt  = PH_DONE;
          end else begin
            phase_nxt = PH_RSTAT;
          end
        end
        PH_RSTAT: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          if (reply_word == RSTAT_ACCEPTED) begin
            phase_nxt = PH_VFLAVOR;
          end else if (reply_word == RSTAT_DENIED) begin
            phase_nxt = PH_REJECT;
          end else begin
            res.hit    = 1'b1;
            res.status = ST_BAD_RPC;
            phase_nxt  = PH_DONE;
          end
        end
        PH_REJECT: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          if (reply_word == REJ_RPC_MISM) begin
            res.hit    = 1'b1;
            res.status = ST_RPC_MISMATCH;
            phase_nxt  = PH_DONE;
          end else if (reply_word == REJ_AUTH_ERR) begin
            phase_nxt = PH_AUTH;
          end else begin
            res.hit    = 1'b1;
            res.status = ST_BAD_RPC;
            phase_nxt  = PH_DONE;
          end
        end
        PH_AUTH: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          res.hit        = 1'b1;
          phase_nxt      = PH_DONE;
          if (reply_word == AUTH_CRED_BAD || reply_word == AUTH_REJCRED) begin
            res.status = ST_AUTH;
          end else if (reply_word == AUTH_WEAK_FLAVOR) begin
            res.status = ST_NEED_AUTH;
          end else begin
            res.status = ST_BAD_RPC;
          end
        end
        PH_VFLAVOR: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          phase_nxt      = PH_VLEN;
        end
        PH_VLEN: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          if (reply_word > MAX_LEN) begin
            res.hit    = 1'b1;
            res.status = ST_BAD_RPC;
            phase_nxt  = PH_DONE;
          end else begin
            // round the byte length up to whole words
            skip_left_nxt = SKIP_W'(len_round >> 2);
            phase_nxt     = (len_round[LEN_W:2] == '0) ? PH_ACCEPT : PH_VSKIP;
          end
        end
        PH_VSKIP: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          skip_left_nxt  = skip_left_r - SKIP_W'(1);
          if (skip_left_r == SKIP_W'(1)) begin
            phase_nxt = PH_ACCEPT;
          end
        end
        PH_ACCEPT: begin
          word_index_nxt = word_index_r + PIDX_W'(1);
          res.hit        = 1'b1;
          phase_nxt      = PH_DONE;
          if (reply_word == ACC_SUCCESS) begin
            res.status        = ST_OK;
            res.payload_index = word_index_r + PIDX_W'(2);
          end else if (reply_word == ACC_PROG_UNAV) begin
            res.status = ST_PROG_UNAVAIL;
          end else if (reply_word == ACC_PROG_MISM) begin
            res.status = ST_PROG_MISMATCH;
          end else if (reply_word == ACC_PROC_UNAV) begin
            res.status = ST_PROC_UNAVAIL;
          end else begin
            res.status = ST_BAD_RPC;
          end
        end
        default: begin
          // idle or finished: drop the word
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_IDLE;
      skip_left_r  <= '0;
      word_index_r <= '0;
    end else if (step) begin
      phase_r      <= phase_nxt;
      skip_left_r  <= skip_left_nxt;
      word_index_r <= word_index_nxt;
    end
  end

  a_skip_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_VSKIP |-> skip_left_r != '0)
    else $error("verifier skip phase with zero words left");

  a_payload_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    res.hit && res.status != ST_OK |-> res.payload_index == '0)
    else $error("payload index set on a failing status");

  a_done_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.hit |=> phase_r == PH_DONE)
    else $error("result emitted without closing the message");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_IDLE |-> word_index_r == '0 && skip_left_r == '0)
    else $error("idle parser holds stale counters");

endmodule

[src/rpc_reply_status_decoder_unit.sv]
// Timing: an accepted word waits in the input register and decodes into the result
//   register, which drives out_valid.
// Throughput: one reply word per cycle; the input stalls only while a word that finishes
//   a message waits behind a result that is itself stalled.
// Reset: synchronous, active low; clears both valid flags and returns the parser to idle.
module rpc_reply_status_decoder_unit
  import rrsd_pkg::*;
#(
  parameter int MAX_VERF_BYTES = 400
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [WORD_W-1:0]   in_reply_word,
  input  logic                in_first_word,
  input  logic [WORD_W-1:0]   in_expected_xid,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [STATUS_W-1:0] out_status,
  output logic [PIDX_W-1:0]   out_payload_index
);

  // Input register: one word waiting for decode
  logic              s1_valid_r, s1_valid_nxt;
  logic [WORD_W-1:0] s1_word_r;
  logic              s1_first_r;
  logic [WORD_W-1:0] s1_xid_r;

  // Result register
  logic                out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [PIDX_W-1:0]   out_payload_index_r;

  rrsd_res_t res;
  logic      out_free;
  logic      s1_go;
  logic      step;
  logic      in_xfer;

  // The result register can take a new result when empty or draining this cycle.
  assign out_free = !out_valid_r || !out_stall;
  // A word that yields no result always advances; one that yields a result
  // needs room in the result register.
  assign s1_go    = !res.hit || out_free;
  assign step     = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;
  assign in_xfer  = in_valid && !in_stall;

  rrsd_parser #(
    .MAX_VERF_BYTES(MAX_VERF_BYTES)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (s1_valid_r),
    .step         (step),
    .reply_word   (s1_word_r),
    .first_word   (s1_first_r),
    .expected_xid (s1_xid_r),
    .res          (res)
  );

  always_comb begin
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (step && res.hit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture a word on every input transfer; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_word_r  <= in_reply_word;
      s1_first_r <= in_first_word;
      s1_xid_r   <= in_expected_xid;
    end
  end

  // Load a result only when the parser finishes a message this cycle.
  always_ff @(posedge clk) begin
    if (step && res.hit) begin
      out_status_r        <= res.status;
      out_payload_index_r <= res.payload_index;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_payload_index = out_payload_index_r;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(step && res.hit))
    else $error("result overwritten while stalled");

  a_stall_holds_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && res.hit)
    else $error("input stalled without a pending result");

  a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
    step && res.hit |=> out_valid_r)
    else $error("finished message produced no result");

endmodule
